>>> rtl/core/lpti_pkg.sv
// ---------------------------------------------------------------------------
// lpti_pkg
// shared types and constants of the line projected table interpolator
// ---------------------------------------------------------------------------
package lpti_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 53;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TABLE_DEPTH - 1) << 16;
    localparam logic [16:0]      FRAC_ONE  = 17'h10000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_AXIS_X     = 3'd3,
        REG_AXIS_Y     = 3'd4,
        REG_AXIS_Z     = 3'd5,
        REG_GRID_START = 3'd6,
        REG_INV_STEP   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic               opcode;
        logic        [5:0]  sample_index;
        logic signed [31:0] sample_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               out_of_range;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [17:0] axis_x;
        logic signed [17:0] axis_y;
        logic signed [17:0] axis_z;
        logic signed [31:0] grid_start;
        logic        [30:0] inv_step;
    } t_cfg;

    // projected word leaving the projection stages
    typedef struct packed {
        logic               vld;
        logic               query;
        logic        [5:0]  widx;
        logic signed [31:0] wval;
        logic signed [37:0] rel;
    } t_rel;

    // located word entering the table stages
    typedef struct packed {
        logic               vld;
        logic               query;
        logic               wr_en;
        logic [ADDR_W-1:0]  waddr;
        logic signed [31:0] wval;
        logic [ADDR_W-1:0]  cidx;
        logic [16:0]        frac;
        logic               oor;
    } t_cell;

endpackage

>>> rtl/core/lpti_cfg_regs.sv
// ---------------------------------------------------------------------------
// lpti_cfg_regs
// configuration register file, one register written per accepted word
// ---------------------------------------------------------------------------
module lpti_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output lpti_pkg::t_cfg o_cfg
);
    import lpti_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X:   n_cfg.origin_x   = i_cfg_data;
                REG_ORIGIN_Y:   n_cfg.origin_y   = i_cfg_data;
                REG_ORIGIN_Z:   n_cfg.origin_z   = i_cfg_data;
                REG_AXIS_X:     n_cfg.axis_x     = i_cfg_data[17:0];
                REG_AXIS_Y:     n_cfg.axis_y     = i_cfg_data[17:0];
                REG_AXIS_Z:     n_cfg.axis_z     = i_cfg_data[17:0];
                REG_GRID_START: n_cfg.grid_start = i_cfg_data;
                REG_INV_STEP:   n_cfg.inv_step   = i_cfg_data[30:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= 32'sd0;
            r_cfg.origin_y   <= 32'sd0;
            r_cfg.origin_z   <= 32'sd0;
            r_cfg.axis_x     <= 18'sd65536;
            r_cfg.axis_y     <= 18'sd0;
            r_cfg.axis_z     <= 18'sd0;
            r_cfg.grid_start <= 32'sd0;
            r_cfg.inv_step   <= 31'd65536;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/core/lpti_project.sv
// ---------------------------------------------------------------------------
// lpti_project
// four stages: offset from origin, axis products, dot sum, line coordinate
// ---------------------------------------------------------------------------
module lpti_project (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  lpti_pkg::t_in_word i_word,
    input  lpti_pkg::t_cfg     i_cfg,
    output lpti_pkg::t_rel     o_rel
);
    import lpti_pkg::*;

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic               r1_query, r2_query, r3_query, r4_query;
    logic        [5:0]  r1_widx, r2_widx, r3_widx, r4_widx;
    logic signed [31:0] r1_wval, r2_wval, r3_wval, r4_wval;
    logic signed [32:0] r1_dx, r1_dy, r1_dz;
    logic signed [50:0] r2_px, r2_py, r2_pz;
    logic signed [52:0] r3_sum;
    logic signed [37:0] r4_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_query <= (i_word.opcode == OP_QUERY);
        r1_widx  <= i_word.sample_index;
        r1_wval  <= i_word.sample_value;
        r1_dx    <= {i_word.point_x[31], i_word.point_x} - {i_cfg.origin_x[31], i_cfg.origin_x};
        r1_dy    <= {i_word.point_y[31], i_word.point_y} - {i_cfg.origin_y[31], i_cfg.origin_y};
        r1_dz    <= {i_word.point_z[31], i_word.point_z} - {i_cfg.origin_z[31], i_cfg.origin_z};

        r2_query <= r1_query;
        r2_widx  <= r1_widx;
        r2_wval  <= r1_wval;
        r2_px    <= r1_dx * i_cfg.axis_x;
        r2_py    <= r1_dy * i_cfg.axis_y;
        r2_pz    <= r1_dz * i_cfg.axis_z;

        r3_query <= r2_query;
        r3_widx  <= r2_widx;
        r3_wval  <= r2_wval;
        r3_sum   <= {{2{r2_px[50]}}, r2_px} + {{2{r2_py[50]}}, r2_py}
                  + {{2{r2_pz[50]}}, r2_pz};

        // floor of the q21.32 sum to q21.16, then relative to the grid start
        r4_query <= r3_query;
        r4_widx  <= r3_widx;
        r4_wval  <= r3_wval;
        r4_rel   <= {r3_sum[52], r3_sum[52:16]} - {{6{i_cfg.grid_start[31]}}, i_cfg.grid_start};
    end

    always_comb begin
        o_rel.vld   = r4_vld;
        o_rel.query = r4_query;
        o_rel.widx  = r4_widx;
        o_rel.wval  = r4_wval;
        o_rel.rel   = r4_rel;
    end

endmodule

>>> rtl/core/lpti_locate.sv
// ---------------------------------------------------------------------------
// lpti_locate
// two stages: scale by the inverse step, then clamp and split into cell
// index and fraction
// ---------------------------------------------------------------------------
module lpti_locate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpti_pkg::t_rel i_rel,
    input  lpti_pkg::t_cfg i_cfg,
    output lpti_pkg::t_cell o_cell
);
    import lpti_pkg::*;

    logic               r5_vld, r6_vld;
    logic               r5_query, r6_query;
    logic               r5_wr_en, r6_wr_en;
    logic [ADDR_W-1:0]  r5_waddr, r6_waddr;
    logic signed [31:0] r5_wval, r6_wval;
    logic               r5_neg;
    logic        [51:0] r5_hi;
    logic        [30:0] r5_lo;
    logic [ADDR_W-1:0]  r6_cidx;
    logic [16:0]        r6_frac;
    logic               r6_oor;

    logic        [46:0] lo_full;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_c;
    logic               over;
    logic [ADDR_W-1:0]  idx_raw;
    logic [ADDR_W-1:0]  n_cidx;
    logic [16:0]        n_frac;

    assign lo_full = i_rel.rel[15:0] * i_cfg.inv_step;

    always_comb begin
        pos     = r5_neg ? '0 : (POS_W'(r5_hi) + POS_W'(r5_lo));
        over    = (pos > POS_LIMIT);
        pos_c   = over ? POS_LIMIT : pos;
        idx_raw = pos_c[16 +: ADDR_W];
        // exact last grid point stays in the last cell with a full fraction
        if (idx_raw == ADDR_W'(TABLE_DEPTH - 1)) begin
            n_cidx = ADDR_W'(TABLE_DEPTH - 2);
            n_frac = FRAC_ONE;
        end else begin
            n_cidx = idx_raw;
            n_frac = {1'b0, pos_c[15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r5_vld <= i_rel.vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_query <= i_rel.query;
        r5_wr_en <= !i_rel.query && (32'(i_rel.widx) < 32'(TABLE_DEPTH));
        r5_waddr <= ADDR_W'(i_rel.widx);
        r5_wval  <= i_rel.wval;
        r5_neg   <= i_rel.rel[37];
        r5_hi    <= i_rel.rel[36:16] * i_cfg.inv_step;
        r5_lo    <= lo_full[46:16];

        r6_query <= r5_query;
        r6_wr_en <= r5_wr_en;
        r6_waddr <= r5_waddr;
        r6_wval  <= r5_wval;
        r6_cidx  <= n_cidx;
        r6_frac  <= n_frac;
        r6_oor   <= r5_neg | over;
    end

    always_comb begin
        o_cell.vld   = r6_vld;
        o_cell.query = r6_query;
        o_cell.wr_en = r6_wr_en;
        o_cell.waddr = r6_waddr;
        o_cell.wval  = r6_wval;
        o_cell.cidx  = r6_cidx;
        o_cell.frac  = r6_frac;
        o_cell.oor   = r6_oor;
    end

endmodule

>>> rtl/core/lpti_table_lerp.sv
// ---------------------------------------------------------------------------
// lpti_table_lerp
// sample memory with two registered reads, then three stages of linear
// interpolation and saturation
// ---------------------------------------------------------------------------
module lpti_table_lerp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpti_pkg::t_cell    i_cell,
    output logic              o_done,
    output lpti_pkg::t_out_word o_word
);
    import lpti_pkg::*;

    logic signed [31:0] r_mem [TABLE_DEPTH];

    logic               r7_vld, r8_vld, r9_vld, r_done;
    logic signed [31:0] r7_s0, r7_s1, r8_s0, r9_s0;
    logic [16:0]        r7_frac, r8_frac;
    logic               r7_oor, r8_oor, r9_oor;
    logic signed [32:0] r8_diff;
    logic signed [50:0] r9_prod;
    t_out_word          r_word;

    logic signed [34:0] val;
    t_out_word          n_word;

    // writes and reads share one stage, so word order is kept
    always_ff @(posedge i_clk) begin
        if (i_cell.vld && i_cell.wr_en) begin
            r_mem[i_cell.waddr] <= i_cell.wval;
        end
        r7_s0 <= r_mem[i_cell.cidx];
        r7_s1 <= r_mem[i_cell.cidx + ADDR_W'(1)];
    end

    always_comb begin
        val = {{3{r9_s0[31]}}, r9_s0} + r9_prod[50:16];
        n_word.out_of_range = r9_oor;
        if (val[34:31] == 4'b0000 || val[34:31] == 4'b1111) begin
            n_word.interp_value = val[31:0];
        end else if (val[34]) begin
            n_word.interp_value = 32'sh8000_0000;
        end else begin
            n_word.interp_value = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r7_vld <= i_cell.vld & i_cell.query;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
            r_done <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_frac <= i_cell.frac;
        r7_oor  <= i_cell.oor;

        r8_s0   <= r7_s0;
        r8_frac <= r7_frac;
        r8_oor  <= r7_oor;
        r8_diff <= {r7_s1[31], r7_s1} - {r7_s0[31], r7_s0};

        r9_s0   <= r8_s0;
        r9_oor  <= r8_oor;
        r9_prod <= r8_diff * $signed({1'b0, r8_frac});

        r_word  <= n_word;
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

>>> rtl/core/line_projected_table_interpolator.sv
// ---------------------------------------------------------------------------
// line_projected_table_interpolator
// projects a q16.16 point onto a line and interpolates a uniform sample table
// ---------------------------------------------------------------------------
// One word is taken in every cycle and busy never rises. A query word gives
// its result on o_out_word, shown for one cycle with o_done;
// the receiver cannot hold it off, so it must take every result as it comes.
// The path is set by the ten register stages (offset, products, dot sum,
// line coordinate, step scaling, clamp, table read, difference, product,
// add and saturate). A write word gives no result; it reaches the sample
// memory in the same stage as the query reads, so a query taken after a
// write sees the new sample. The table is not cleared at reset: write every
// entry a query can reach first. Configuration may be written only while no
// query is in flight; its ready is always high.
// ---------------------------------------------------------------------------
module line_projected_table_interpolator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lpti_pkg::t_in_word   i_in_word,
    output logic                o_done,
    output lpti_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import lpti_pkg::*;

    t_cfg  cfg;
    t_rel  rel;
    t_cell located;
    logic  accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    lpti_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpti_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_rel   (rel)
    );

    lpti_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rel   (rel),
        .i_cfg   (cfg),
        .o_cell  (located)
    );

    lpti_table_lerp u_table_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (located),
        .o_done  (o_done),
        .o_word  (o_out_word)
    );

endmodule
